>>> hw/rtl/ced_pkg.sv
// Shared constants, types and helper functions of the C-style escape decoder.
`timescale 1ns / 1ps

package ced_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_A         = 8'h61;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_V         = 8'h76;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_R         = 8'h72;

  localparam logic [7:0] CTRL_BEL = 8'h07;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_HT  = 8'h09;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_VT  = 8'h0B;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;

  // ASCII '0' through '7' share these upper five bits.
  localparam logic [4:0] OCTAL_PREFIX = 5'b00110;

  // Most decoded bytes one input word can produce.
  localparam int MAX_OUT = 4;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_lookup_t;

  // Backslash plus up to two held digits, spelled out as written.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } flush_t;

  function automatic logic is_octal(input logic [7:0] b);
    return b[7:3] == OCTAL_PREFIX;
  endfunction

  function automatic logic [7:0] digit_char(input logic [2:0] d);
    return {OCTAL_PREFIX, d};
  endfunction

  function automatic esc_lookup_t known_escape(input logic [7:0] b);
    esc_lookup_t r;
    r.hit = 1'b1;
    unique case (b)
      CHAR_BACKSLASH: r.value = CHAR_BACKSLASH;
      CHAR_QUOTE:     r.value = CHAR_QUOTE;
      CHAR_A:         r.value = CTRL_BEL;
      CHAR_B:         r.value = CTRL_BS;
      CHAR_T:         r.value = CTRL_HT;
      CHAR_N:         r.value = CTRL_LF;
      CHAR_V:         r.value = CTRL_VT;
      CHAR_F:         r.value = CTRL_FF;
      CHAR_R:         r.value = CTRL_CR;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic flush_t flush_run(input logic in_octal, input logic [1:0] cnt,
                                       input logic [5:0] held);
    flush_t f;
    f.bytes[0] = CHAR_BACKSLASH;
    f.bytes[1] = 8'h00;
    f.bytes[2] = 8'h00;
    f.len      = 2'd1;
    if (in_octal && cnt == 2'd1) begin
      f.bytes[1] = digit_char(held[2:0]);
      f.len      = 2'd2;
    end else if (in_octal && cnt >= 2'd2) begin
      f.bytes[1] = digit_char(held[5:3]);
      f.bytes[2] = digit_char(held[2:0]);
      f.len      = 2'd3;
    end
    return f;
  endfunction

endpackage

>>> hw/rtl/c_style_escape_decoder_core.sv
// Top level of the C-style escape decoder: escape state, decode logic and output buffer.
`timescale 1ns / 1ps

// The decoder takes one nonzero text byte per input word and returns the
// unescaped bytes as a stream of output words. Plain bytes pass straight
// through; the escapes \\ \" \a \b \t \n \v \f \r and a backslash followed by
// exactly three octal digits worth 1 to 255 collapse to one byte. Anything
// else is given back as written, and an escape still open when in_tlast
// arrives is flushed the same way, with out_tlast on the last byte of the
// string. An input word is decoded in the cycle it is accepted and its bytes
// (zero to four) land in a four-entry output buffer that drains one byte per
// cycle while out_tready is high. Most words give one byte, so the block then
// sustains one word per cycle; a word that gives more bytes holds off input and
// the next word is taken in the same cycle that the last of them leaves. The
// output buffer is the only thing that sets the rate. There is no startup delay.
module c_style_escape_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] plain_byte
  output logic       out_tlast   // final_byte
);

  import ced_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_BACKSLASH,
    MODE_OCTAL
  } mode_t;

  // Escape state carried from one word to the next.
  mode_t      mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [5:0] held_r, held_nxt;

  // Output buffer: entry 0 is the byte on out_tdata, later entries shift down.
  logic [MAX_OUT-1:0][7:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic                    last_r;

  logic        accept;
  logic        take;
  esc_lookup_t esc;
  flush_t      fl_cur;
  flush_t      fl_end;
  logic [8:0]  oct_value;
  logic [2:0]  digit;

  assign take      = out_tvalid && out_tready;
  // Accept while the buffer is empty or its final byte is leaving now.
  assign in_tready = (rem_r == '0) || ((rem_r == CNT_W'(1)) && out_tready);
  assign accept    = in_tvalid && in_tready;

  assign esc       = known_escape(in_tdata);
  assign digit     = in_tdata[2:0];
  assign oct_value = {held_r, digit};
  assign fl_cur    = flush_run(mode_r == MODE_OCTAL, cnt_r, held_r);

  always_comb begin
    buf_nxt  = '0;
    rem_nxt  = '0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    fl_end   = '0;

    unique case (mode_r)
      MODE_BACKSLASH: begin
        if (esc.hit) begin
          buf_nxt[0] = esc.value;
          rem_nxt    = CNT_W'(1);
          mode_nxt   = MODE_PLAIN;
        end else if (is_octal(in_tdata)) begin
          mode_nxt = MODE_OCTAL;
          cnt_nxt  = 2'd1;
          held_nxt = {3'b000, digit};
        end else begin
          // Unknown escape: give the backslash back, then treat the byte as text.
          buf_nxt[0] = CHAR_BACKSLASH;
          rem_nxt    = CNT_W'(1);
          cnt_nxt    = 2'd0;
          held_nxt   = 6'd0;
          if (in_tdata == CHAR_BACKSLASH) begin
            mode_nxt = MODE_BACKSLASH;
          end else begin
            mode_nxt   = MODE_PLAIN;
            buf_nxt[1] = in_tdata;
            rem_nxt    = CNT_W'(2);
          end
        end
      end
      MODE_OCTAL: begin
        if (is_octal(in_tdata) && cnt_r < 2'd2) begin
          cnt_nxt  = cnt_r + 2'd1;
          held_nxt = {held_r[2:0], digit};
        end else if (is_octal(in_tdata) && oct_value != 9'd0 && !oct_value[8]) begin
          // Third digit of a run worth 1 to 255.
          buf_nxt[0] = oct_value[7:0];
          rem_nxt    = CNT_W'(1);
          mode_nxt   = MODE_PLAIN;
          cnt_nxt    = 2'd0;
          held_nxt   = 6'd0;
        end else begin
          // Bad or short run: spell it out, then handle the byte that ended it.
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < fl_cur.len) begin
              buf_nxt[rem_nxt[1:0]] = fl_cur.bytes[i];
              rem_nxt               = rem_nxt + CNT_W'(1);
            end
          end
          cnt_nxt  = 2'd0;
          held_nxt = 6'd0;
          if (in_tdata == CHAR_BACKSLASH) begin
            mode_nxt = MODE_BACKSLASH;
          end else begin
            mode_nxt              = MODE_PLAIN;
            buf_nxt[rem_nxt[1:0]] = in_tdata;
            rem_nxt               = rem_nxt + CNT_W'(1);
          end
        end
      end
      default: begin
        cnt_nxt  = 2'd0;
        held_nxt = 6'd0;
        if (in_tdata == CHAR_BACKSLASH) begin
          mode_nxt = MODE_BACKSLASH;
        end else begin
          mode_nxt   = MODE_PLAIN;
          buf_nxt[0] = in_tdata;
          rem_nxt    = CNT_W'(1);
        end
      end
    endcase

    // End of string: flush any escape still open and start the next string clean.
    if (in_tlast) begin
      if (mode_nxt != MODE_PLAIN) begin
        fl_end = flush_run(mode_nxt == MODE_OCTAL, cnt_nxt, held_nxt);
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < fl_end.len) begin
            buf_nxt[rem_nxt[1:0]] = fl_end.bytes[i];
            rem_nxt               = rem_nxt + CNT_W'(1);
          end
        end
      end
      mode_nxt = MODE_PLAIN;
      cnt_nxt  = 2'd0;
      held_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 2'd0;
      held_r <= 6'd0;
      rem_r  <= '0;
      last_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      buf_r  <= buf_nxt;
      rem_r  <= rem_nxt;
      last_r <= in_tlast;
    end else if (take) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      rem_r <= rem_r - CNT_W'(1);
    end
  end

  assign out_tvalid = rem_r != '0;
  assign out_tdata  = buf_r[0];
  assign out_tlast  = last_r && (rem_r == CNT_W'(1));

endmodule

>>> verif/ced_decode_checker.sv
// Checker for the escape decoder: predicts decoded bytes from accepted text and compares.
`timescale 1ns / 1ps

module ced_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         mismatch_count,
  output int         bytes_owed
);

  import ced_pkg::*;

  typedef enum logic [1:0] {
    ST_TEXT,
    ST_SLASH,
    ST_DIGITS
  } esc_state_t;

  typedef struct {
    logic [7:0] plain;
    logic       is_last;
  } decoded_byte_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;

  esc_state_t    esc_state;
  logic [1:0]    digits_held;
  logic [5:0]    digit_bits;
  decoded_byte_t decoded_due[$];
  int            errors = 0;

  function automatic void push_plain(input logic [7:0] b);
    decoded_byte_t d;
    d.plain   = b;
    d.is_last = 1'b0;
    decoded_due.push_back(d);
  endfunction

  function automatic void clear_escape();
    esc_state   = ST_TEXT;
    digits_held = 2'd0;
    digit_bits  = 6'd0;
  endfunction

  // An escape that did not complete goes out exactly as it was written.
  function automatic void spill_escape();
    push_plain(CHAR_BACKSLASH);
    if (esc_state == ST_DIGITS) begin
      if (digits_held == 2'd1) begin
        push_plain(CHAR_ZERO + digit_bits[2:0]);
      end else if (digits_held >= 2'd2) begin
        push_plain(CHAR_ZERO + digit_bits[5:3]);
        push_plain(CHAR_ZERO + digit_bits[2:0]);
      end
    end
    clear_escape();
  endfunction

  function automatic void take_text(input logic [7:0] b);
    if (b == CHAR_BACKSLASH) begin
      clear_escape();
      esc_state = ST_SLASH;
    end else begin
      push_plain(b);
    end
  endfunction

  // Bit 8 flags a recognized escape letter, bits 7:0 hold the byte it stands for.
  function automatic logic [8:0] letter_value(input logic [7:0] b);
    unique case (b)
      CHAR_BACKSLASH: return {1'b1, CHAR_BACKSLASH};
      CHAR_QUOTE:     return {1'b1, CHAR_QUOTE};
      CHAR_A:         return {1'b1, CTRL_BEL};
      CHAR_B:         return {1'b1, CTRL_BS};
      CHAR_T:         return {1'b1, CTRL_HT};
      CHAR_N:         return {1'b1, CTRL_LF};
      CHAR_V:         return {1'b1, CTRL_VT};
      CHAR_F:         return {1'b1, CTRL_FF};
      CHAR_R:         return {1'b1, CTRL_CR};
      default:        return 9'd0;
    endcase
  endfunction

  function automatic void decode_text_byte(input logic [7:0] b, input logic last);
    int         start;
    logic [8:0] lookup;
    logic [8:0] code;
    logic       octal;
    start  = decoded_due.size();
    lookup = letter_value(b);
    octal  = (b >= 8'h30) && (b <= 8'h37);
    unique case (esc_state)
      ST_SLASH: begin
        if (lookup[8]) begin
          push_plain(lookup[7:0]);
          clear_escape();
        end else if (octal) begin
          esc_state   = ST_DIGITS;
          digits_held = 2'd1;
          digit_bits  = {3'b000, b[2:0]};
        end else begin
          spill_escape();
          take_text(b);
        end
      end
      ST_DIGITS: begin
        if (!octal) begin
          spill_escape();
          take_text(b);
        end else if (digits_held == 2'd2) begin
          code = {digit_bits, b[2:0]};
          if (code >= 9'd1 && code <= 9'd255) begin
            push_plain(code[7:0]);
            clear_escape();
          end else begin
            spill_escape();
            push_plain(b);
          end
        end else begin
          digits_held = digits_held + 2'd1;
          digit_bits  = {digit_bits[2:0], b[2:0]};
        end
      end
      default: take_text(b);
    endcase
    if (last) begin
      if (esc_state != ST_TEXT) spill_escape();
      if (decoded_due.size() > start) decoded_due[decoded_due.size() - 1].is_last = 1'b1;
      clear_escape();
    end
  endfunction

  always @(posedge clk) begin
    decoded_byte_t want;
    if (!rst_n) begin
      decoded_due.delete();
      clear_escape();
    end else begin
      if (in_tvalid && in_tready) decode_text_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (decoded_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected output word data=%02h last=%0b", $realtime,
                     out_tdata, out_tlast);
          errors++;
        end else begin
          want = decoded_due.pop_front();
          if (out_tdata !== want.plain || out_tlast !== want.is_last) begin
            if (errors < 10)
              $display("%0t: output word expected data=%02h last=%0b, got data=%02h last=%0b",
                       $realtime, want.plain, want.is_last, out_tdata, out_tlast);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    bytes_owed     <= decoded_due.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the escape decoder: clock, reset, text stimulus, output pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ced_pkg::*;

  // A stretch this long with no word accepted on either side means the block hung.
  localparam int HANG_LIMIT = 2000;
  // Cycles of output hold-off used to fill the output buffer on purpose.
  localparam int LONG_STALL = 60;
  // Least number of random text words sent in each idling phase.
  localparam int PHASE_WORDS = 45;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int mismatch_count;
  int bytes_owed;

  // Idle rates in percent for each side; the stimulus changes them per phase.
  int send_idle_pct = 28;
  int recv_idle_pct = 74;
  // Number of long stalls asked for by the stimulus; the pacing process serves them.
  int stall_request = 0;
  int quiet_cycles  = 0;

  always #4 clk = ~clk;

  c_style_escape_decoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ced_decode_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .bytes_owed    (bytes_owed)
  );

  // Output pacing. A pending stall request takes priority and holds tready low for the
  // whole stretch, counted here, so the block backs up into its input while the sender
  // keeps offering words. Otherwise tready drops at the current idle rate.
  initial begin
    int stall_taken;
    stall_taken = 0;
    forever begin
      @(posedge clk);
      if (stall_taken < stall_request) begin
        stall_taken++;
        out_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Hang detection: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("c_style_escape_decoder_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one text word and return at the edge where it is taken. tvalid is only lowered
  // inside an idle gap, so back-to-back words keep it high without a glitch.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Sends a whole string; the final character carries tlast.
  task automatic send_text(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
  endtask

  task automatic send_literal(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text);
  endtask

  // Random string built from pieces: plain bytes, letter escapes, three-digit octal
  // escapes (some out of range or zero), short octal runs and escapes of random bytes.
  // Returns the number of words it sent.
  task automatic send_random_text(output int sent);
    logic [7:0] text[$];
    logic [7:0] letters[9];
    int         pieces;
    int         pick;
    letters = '{CHAR_BACKSLASH, CHAR_QUOTE, CHAR_A, CHAR_B, CHAR_T, CHAR_N, CHAR_V, CHAR_F,
                CHAR_R};
    pieces  = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        text.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 65) begin
        text.push_back(CHAR_BACKSLASH);
        text.push_back(letters[$urandom_range(8)]);
      end else if (pick < 85) begin
        text.push_back(CHAR_BACKSLASH);
        if ($urandom_range(15) == 0) begin
          repeat (3) text.push_back(8'h30);
        end else begin
          repeat (3) text.push_back(8'h30 + 8'($urandom_range(7)));
        end
      end else if (pick < 95) begin
        text.push_back(CHAR_BACKSLASH);
        repeat ($urandom_range(1, 2)) text.push_back(8'h30 + 8'($urandom_range(7)));
      end else begin
        text.push_back(CHAR_BACKSLASH);
        text.push_back(8'($urandom_range(1, 255)));
      end
    end
    send_text(text);
    sent = text.size();
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (bytes_owed != 0);
  endtask

  initial begin
    int sent;
    int phase_count;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Byte range extremes, then the common escapes and each way an
    // escape can end: a valid octal code at the top of the range, octal zero, a code
    // above 377, a short run broken by a backslash that opens an unknown escape, and
    // escapes still open when the string ends.
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b1);
    send_literal("\\n\\\\");
    send_literal("\\377");
    send_literal("\\000");
    send_literal("\\400");
    send_literal("\\7\\q");
    send_literal("\\1");
    send_literal("\\");

    // Three idling phases: receiver sparse then sender sparse, and finally neither.
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 28;
        end
        default: begin
          // Let every pending byte come out before the full-rate phase, then fill the
          // output buffer with a long receiver stall while words keep coming.
          wait_drained();
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_request = stall_request + 1;
        end
      endcase
      phase_count = 0;
      while (phase_count < PHASE_WORDS) begin
        send_random_text(sent);
        phase_count += sent;
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && bytes_owed == 0) begin
      $display("c_style_escape_decoder_core: match");
    end else begin
      $display("c_style_escape_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ced_pkg.sv
hw/rtl/c_style_escape_decoder_core.sv
verif/ced_decode_checker.sv
verif/tb_top.sv
